/* src/dctf_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Draw-call throttle filter package
// Shared widths, operation and primitive codes, register indexes and resets.
// ---------------------------------------------------------------------------
package dctf_pkg;

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned PRIM_W  = 3;
  localparam int unsigned VCNT_W  = 24;
  localparam int unsigned TIME_W  = 24;
  localparam int unsigned SBL_W   = 16;
  localparam int unsigned FRM_W   = 8;
  localparam int unsigned LEVEL_W = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ARRAYS   = 2'd0,
    OP_ELEMENTS = 2'd1,
    OP_TICK     = 2'd2,
    OP_RSVD     = 2'd3
  } op_t;

  // Primitive codes that the filter cares about
  localparam logic [PRIM_W-1:0] PRIM_POINTS = 3'd0;
  localparam logic [PRIM_W-1:0] PRIM_TRIS   = 3'd4;
  localparam logic [PRIM_W-1:0] PRIM_STRIP  = 3'd5;
  localparam logic [PRIM_W-1:0] PRIM_FAN    = 3'd6;

  // Throttle levels
  localparam logic [LEVEL_W-1:0] LVL_NONE  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_LIGHT = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_HEAVY = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_BAD   = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_BATCH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UP_FRAMES   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_FRAMES = 3'd5;

  // Register reset values (limits are 90% and 110% of a 35714 us budget)
  localparam logic [TIME_W-1:0] RST_LOW_LIMIT   = 24'd32143;
  localparam logic [TIME_W-1:0] RST_HIGH_LIMIT  = 24'd39286;
  localparam logic [SBL_W-1:0]  RST_SMALL_BATCH = 16'd12;
  localparam logic [FRM_W-1:0]  RST_UP_FRAMES   = 8'd2;
  localparam logic [FRM_W-1:0]  RST_DOWN_FRAMES = 8'd8;

  localparam logic [FRM_W-1:0] CNT_MAX = '1;

endpackage

/* src/draw_call_throttle_filter_top.sv */
`timescale 1ns / 1ps
// An accepted input word's result word is registered and appears in the cycle after.
// Throughput: one word per cycle; the output register decouples the sides,
//   and in_stall is raised only while a held result is itself stalled.
// Reset (rst_n low, synchronous): level and hysteresis counters clear,
//   the output register empties, registers return to their defaults.
// ---------------------------------------------------------------------------
// Draw-call throttle filter, top level
// Drops point array draws and small-triangle draws according to a throttle level that
// frame-time ticks move with hysteresis.
// ---------------------------------------------------------------------------
module draw_call_throttle_filter_top
  import dctf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_op,
  input  logic [PRIM_W-1:0]    in_prim_mode,
  input  logic [VCNT_W-1:0]    in_vertex_count,
  input  logic                 in_idle_frame,
  input  logic [TIME_W-1:0]    in_frame_time_us,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_forward,
  output logic [LEVEL_W-1:0]   out_level
);

  // Configuration registers
  logic               enable_r;
  logic [TIME_W-1:0]  low_limit_r;
  logic [TIME_W-1:0]  high_limit_r;
  logic [SBL_W-1:0]   small_batch_r;
  logic [FRM_W-1:0]   up_frames_r;
  logic [FRM_W-1:0]   down_frames_r;

  // Throttle state
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [FRM_W-1:0]   heavy_r, heavy_nxt;
  logic [FRM_W-1:0]   light_r, light_nxt;

  // Output register
  logic               out_valid_r;
  logic               forward_r, forward_nxt;
  logic [LEVEL_W-1:0] out_level_r;

  logic               in_acc;
  logic               out_acc;
  op_t                op;
  logic [LEVEL_W-1:0] desired;
  logic [FRM_W-1:0]   heavy_inc, light_inc;
  logic               is_tri;
  logic               drop;

  assign op       = op_t'(in_op);
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign out_acc  = out_valid_r & ~out_stall;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b0;
      low_limit_r   <= RST_LOW_LIMIT;
      high_limit_r  <= RST_HIGH_LIMIT;
      small_batch_r <= RST_SMALL_BATCH;
      up_frames_r   <= RST_UP_FRAMES;
      down_frames_r <= RST_DOWN_FRAMES;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ENABLE:      enable_r      <= cfg_wdata[0];
        REG_LOW_LIMIT:   low_limit_r   <= cfg_wdata[TIME_W-1:0];
        REG_HIGH_LIMIT:  high_limit_r  <= cfg_wdata[TIME_W-1:0];
        REG_SMALL_BATCH: small_batch_r <= cfg_wdata[SBL_W-1:0];
        REG_UP_FRAMES:   up_frames_r   <= cfg_wdata[FRM_W-1:0];
        REG_DOWN_FRAMES: down_frames_r <= cfg_wdata[FRM_W-1:0];
        default: ;
      endcase
    end
  end

  // Draw filter
  assign is_tri = (in_prim_mode == PRIM_TRIS) | (in_prim_mode == PRIM_STRIP) |
                  (in_prim_mode == PRIM_FAN);

  always_comb begin
    drop = 1'b0;
    if (enable_r && level_r != LVL_NONE) begin
      if (op == OP_ARRAYS && in_prim_mode == PRIM_POINTS)
        drop = 1'b1;
      if (level_r >= LVL_HEAVY && is_tri &&
          in_vertex_count < {{(VCNT_W-SBL_W){1'b0}}, small_batch_r})
        drop = 1'b1;
    end
  end

  // Desired level from the frame time, low limit checked first
  always_comb begin
    priority if (in_frame_time_us < low_limit_r) desired = LVL_NONE;
    else if (in_frame_time_us < high_limit_r)    desired = LVL_LIGHT;
    else                                         desired = LVL_HEAVY;
  end

  assign heavy_inc = (heavy_r == CNT_MAX) ? CNT_MAX : heavy_r + 1'b1;
  assign light_inc = (light_r == CNT_MAX) ? CNT_MAX : light_r + 1'b1;

  // Hysteresis and result
  always_comb begin
    level_nxt   = level_r;
    heavy_nxt   = heavy_r;
    light_nxt   = light_r;
    forward_nxt = 1'b0;
    unique case (op)
      OP_ARRAYS, OP_ELEMENTS: begin
        forward_nxt = ~drop;
      end
      OP_TICK: begin
        if (enable_r && !in_idle_frame) begin
          priority if (desired > level_r) begin
            light_nxt = '0;
            if (heavy_inc >= up_frames_r) begin
              level_nxt = desired;
              heavy_nxt = '0;
            end else begin
              heavy_nxt = heavy_inc;
            end
          end else if (desired < level_r) begin
            heavy_nxt = '0;
            if (light_inc >= down_frames_r) begin
              level_nxt = level_r - 1'b1;
              light_nxt = '0;
            end else begin
              light_nxt = light_inc;
            end
          end else begin
            heavy_nxt = '0;
            light_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= LVL_NONE;
      heavy_r     <= '0;
      light_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        level_r <= level_nxt;
        heavy_r <= heavy_nxt;
        light_r <= light_nxt;
      end
      if (in_acc)
        out_valid_r <= 1'b1;
      else if (out_acc)
        out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      forward_r   <= forward_nxt;
      out_level_r <= level_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_forward = forward_r;
  assign out_level   = out_level_r;

endmodule

/* src/dctf_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Draw-call throttle filter port checker
// Watches the top-level ports; bound to the top level below.
// ---------------------------------------------------------------------------
module dctf_checker
  import dctf_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [OP_W-1:0]    in_op,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_forward,
  input logic [LEVEL_W-1:0] out_level
);

  // A stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_forward) && $stable(out_level)))
    else $error("result word changed while stalled");

  // An accepted word always yields a result on the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted word gave no result");

  // Ticks and unused codes never forward
  a_tick_no_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_op == OP_TICK || in_op == OP_RSVD))
      |=> !out_forward)
    else $error("non-draw word forwarded");

  // Input is held off only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && out_level != LVL_BAD))
    else $error("input stalled without cause or bad level");

endmodule

bind draw_call_throttle_filter_top dctf_checker u_dctf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_op       (in_op),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_forward (out_forward),
  .out_level   (out_level)
);

/* bench/tb_draw_call_throttle_filter_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Draw-call throttle filter testbench
// Sends draw and frame-tick words in random bursts, stalls the result side
// on its own pattern, and compares every result word with an in-bench
// model of the throttle level, the hysteresis counters and the drop rules.
// Register settings change between phases while the block is drained.
// ---------------------------------------------------------------------------
module tb_draw_call_throttle_filter_top;
  import dctf_pkg::*;

  localparam int unsigned TIME_MAX = (1 << TIME_W) - 1;
  localparam int unsigned VCNT_MAX = (1 << VCNT_W) - 1;

  // one input word and one result word
  typedef struct {
    op_t               op;
    logic [PRIM_W-1:0] prim;
    logic [VCNT_W-1:0] vcount;
    logic              idle;
    logic [TIME_W-1:0] ftime;
  } word_t;

  typedef struct {
    logic               forward;
    logic [LEVEL_W-1:0] level;
  } verdict_t;

  typedef enum {TM_MIXED, TM_HEAVY, TM_LIGHT} tick_bias_t;
  typedef enum {STL_NONE, STL_RANDOM, STL_PERIODIC, STL_LONG} stall_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_op = '0;
  logic [PRIM_W-1:0]    in_prim_mode = '0;
  logic [VCNT_W-1:0]    in_vertex_count = '0;
  logic                 in_idle_frame = 1'b0;
  logic [TIME_W-1:0]    in_frame_time_us = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_forward;
  logic [LEVEL_W-1:0]   out_level;

  draw_call_throttle_filter_top dut (.*);

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register mirror
  logic              lim_enable = 1'b0;
  logic [TIME_W-1:0] low_lim    = RST_LOW_LIMIT;
  logic [TIME_W-1:0] high_lim   = RST_HIGH_LIMIT;
  logic [SBL_W-1:0]  sb_lim     = RST_SMALL_BATCH;
  logic [FRM_W-1:0]  up_frm     = RST_UP_FRAMES;
  logic [FRM_W-1:0]  down_frm   = RST_DOWN_FRAMES;

  // throttle state mirror
  logic [LEVEL_W-1:0] lvl_now   = LVL_NONE;
  logic [FRM_W-1:0]   heavy_run = '0;
  logic [FRM_W-1:0]   light_run = '0;

  word_t       word_q[$];
  verdict_t    verdict_q[$];
  int unsigned queued_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned tick_cnt = 0;
  int unsigned drop_cnt = 0;
  int unsigned heavy_words = 0;

  // Work out the verdict for one accepted word and advance the throttle state
  function automatic verdict_t throttle_step(input word_t w);
    verdict_t           v;
    logic               drop;
    logic               tri_kind;
    logic [LEVEL_W-1:0] want;
    v.forward = 1'b0;
    drop = 1'b0;
    tri_kind = (w.prim == PRIM_TRIS) || (w.prim == PRIM_STRIP) || (w.prim == PRIM_FAN);
    case (w.op)
      OP_ARRAYS, OP_ELEMENTS: begin
        if (lim_enable && lvl_now != LVL_NONE) begin
          // points only drop on array draws
          if (w.op == OP_ARRAYS && w.prim == PRIM_POINTS) drop = 1'b1;
          if (lvl_now >= LVL_HEAVY && tri_kind && w.vcount < sb_lim) drop = 1'b1;
        end
        v.forward = !drop;
        if (drop) drop_cnt++;
      end
      OP_TICK: begin
        tick_cnt++;
        if (lim_enable && !w.idle) begin
          if (w.ftime < low_lim) want = LVL_NONE;
          else if (w.ftime < high_lim) want = LVL_LIGHT;
          else want = LVL_HEAVY;
          if (want > lvl_now) begin
            heavy_run = (heavy_run == CNT_MAX) ? CNT_MAX : heavy_run + 1'b1;
            light_run = '0;
            if (heavy_run >= up_frm) begin
              lvl_now = want;
              heavy_run = '0;
            end
          end else if (want < lvl_now) begin
            light_run = (light_run == CNT_MAX) ? CNT_MAX : light_run + 1'b1;
            heavy_run = '0;
            if (light_run >= down_frm) begin
              lvl_now = lvl_now - 1'b1;
              light_run = '0;
            end
          end else begin
            // tick at the current level
            heavy_run = '0;
            light_run = '0;
          end
        end
      end
      default: ;
    endcase
    v.level = lvl_now;
    if (lvl_now == LVL_HEAVY) heavy_words++;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of words from word_q with random gaps
  // ---------------------------------------------------------------------------
  word_t cur_word;
  int    burst_left = 0;
  int    gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        verdict_q.push_back(throttle_step(cur_word));
      end
      if (!in_valid || !in_stall) begin
        if (burst_left == 0 && gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
          if (word_q.size() != 0) begin
            cur_word = word_q.pop_front();
            in_op            <= cur_word.op;
            in_prim_mode     <= cur_word.prim;
            in_vertex_count  <= cur_word.vcount;
            in_idle_frame    <= cur_word.idle;
            in_frame_time_us <= cur_word.ftime;
            in_valid         <= 1'b1;
            burst_left--;
          end else begin
            in_valid <= 1'b0;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: result checks and the receiver's stall pattern
  // ---------------------------------------------------------------------------
  stall_mode_t stall_mode = STL_NONE;
  int          mode_left = 0;

  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result word with nothing expected: forward %0d level %0d",
                 $time, out_forward, out_level);
      end else begin
        exp_v = verdict_q.pop_front();
        checked_cnt++;
        if (out_forward !== exp_v.forward) begin
          err_cnt++;
          $display("%0t: forward mismatch: expected %0d, got %0d",
                   $time, exp_v.forward, out_forward);
        end
        if (out_level !== exp_v.level) begin
          err_cnt++;
          $display("%0t: level mismatch: expected %0d, got %0d",
                   $time, exp_v.level, out_level);
        end
      end
    end
    // stall pattern changes mode every so often
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      STL_NONE:     out_stall <= 1'b0;
      STL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
      STL_PERIODIC: out_stall <= (mode_left[1:0] != 2'd0);
      default:      out_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic put(input op_t op, input logic [PRIM_W-1:0] prim,
                     input logic [VCNT_W-1:0] vc, input logic idle,
                     input logic [TIME_W-1:0] ft);
    word_t w;
    w.op = op;
    w.prim = prim;
    w.vcount = vc;
    w.idle = idle;
    w.ftime = ft;
    word_q.push_back(w);
    queued_cnt++;
  endtask

  // hold off until every queued word has come back checked
  task automatic wait_results();
    while (checked_cnt != queued_cnt) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val[CFG_DAT_W-1:0];
    case (idx)
      REG_ENABLE:      lim_enable = val[0];
      REG_LOW_LIMIT:   low_lim = val[TIME_W-1:0];
      REG_HIGH_LIMIT:  high_lim = val[TIME_W-1:0];
      REG_SMALL_BATCH: sb_lim = val[SBL_W-1:0];
      REG_UP_FRAMES:   up_frm = val[FRM_W-1:0];
      REG_DOWN_FRAMES: down_frm = val[FRM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input int unsigned en, input int unsigned lo, input int unsigned hi,
                         input int unsigned sb, input int unsigned up, input int unsigned dn);
    write_reg(REG_ENABLE, en);
    write_reg(REG_LOW_LIMIT, lo);
    write_reg(REG_HIGH_LIMIT, hi);
    write_reg(REG_SMALL_BATCH, sb);
    write_reg(REG_UP_FRAMES, up);
    write_reg(REG_DOWN_FRAMES, dn);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random words: ticks aimed at the limits, draws aimed at the batch limit
  task automatic run_random(input int n, input int tick_pct, input tick_bias_t bias,
                            input bit pause_mid);
    op_t               op;
    logic [PRIM_W-1:0] prim;
    logic [VCNT_W-1:0] vc;
    logic              idle;
    logic [TIME_W-1:0] ft;
    int unsigned       lo;
    int unsigned       hi;
    lo = 32'(low_lim);
    hi = 32'(high_lim);
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) wait_results();
      // fields the op ignores still carry noise
      prim = PRIM_W'($urandom_range(0, 7));
      vc = VCNT_W'($urandom_range(0, VCNT_MAX));
      idle = 1'($urandom_range(0, 1));
      ft = TIME_W'($urandom_range(0, TIME_MAX));
      if ($urandom_range(0, 39) == 0) begin
        op = OP_RSVD;
      end else if ($urandom_range(0, 99) < tick_pct) begin
        op = OP_TICK;
        idle = ($urandom_range(0, 7) == 0);
        case (bias)
          TM_HEAVY: ft = TIME_W'($urandom_range(hi, TIME_MAX));
          TM_LIGHT: ft = (lo == 0) ? '0 : TIME_W'($urandom_range(0, lo - 1));
          default: begin
            case ($urandom_range(0, 9))
              0: ft = '0;
              1: ft = '1;
              2: ft = (lo == 0) ? '0 : TIME_W'(lo - 1);
              3: ft = TIME_W'(lo);
              4: ft = (hi == 0) ? '0 : TIME_W'(hi - 1);
              5: ft = TIME_W'(hi);
              6: ft = (lo == 0) ? '0 : TIME_W'($urandom_range(0, lo - 1));
              7: ft = (lo < hi) ? TIME_W'($urandom_range(lo, hi - 1)) : TIME_W'(lo);
              8: ft = TIME_W'($urandom_range(hi, TIME_MAX));
              default: ;
            endcase
          end
        endcase
      end else begin
        op = ($urandom_range(0, 1) != 0) ? OP_ELEMENTS : OP_ARRAYS;
        if ($urandom_range(0, 9) < 6) begin
          case ($urandom_range(0, 3))
            0: prim = PRIM_POINTS;
            1: prim = PRIM_TRIS;
            2: prim = PRIM_STRIP;
            default: prim = PRIM_FAN;
          endcase
        end
        case ($urandom_range(0, 7))
          0: vc = '0;
          1: vc = '1;
          2: vc = (sb_lim == 0) ? '0 : VCNT_W'(sb_lim - 1'b1);
          3: vc = VCNT_W'(sb_lim);
          4: vc = VCNT_W'($urandom_range(0, sb_lim + 2));
          5, 6: vc = VCNT_W'($urandom_range(0, 63));
          default: ;
        endcase
      end
      put(op, prim, vc, idle, ft);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // disabled after reset: points pass, a heavy tick does nothing
    put(OP_ARRAYS, PRIM_POINTS, '0, 1'b0, '0);
    put(OP_TICK, PRIM_POINTS, '0, 1'b0, '1);
    wait_results();

    set_all(1, 1000, 2000, 12, 2, 2);
    put(OP_ARRAYS, PRIM_POINTS, '0, 1'b0, '0);
    put(OP_TICK, 3'd7, '1, 1'b0, 24'd2000);       // heavy, count 1
    put(OP_TICK, PRIM_POINTS, '0, 1'b1, '1);      // idle frame, no change
    put(OP_TICK, PRIM_POINTS, '0, 1'b0, '0);      // same level, counters clear
    put(OP_TICK, PRIM_POINTS, '0, 1'b0, 24'd1999);
    put(OP_TICK, PRIM_POINTS, '0, 1'b0, '1);      // second heavy: up to level 2
    put(OP_ARRAYS, PRIM_POINTS, '1, 1'b0, '0);
    put(OP_ELEMENTS, PRIM_POINTS, '0, 1'b1, '1);  // element points survive
    put(OP_ARRAYS, PRIM_TRIS, 24'd11, 1'b0, '0);
    put(OP_ELEMENTS, PRIM_STRIP, 24'd12, 1'b0, '0);
    put(OP_ELEMENTS, PRIM_FAN, '0, 1'b0, '0);
    put(OP_ARRAYS, 3'd1, '0, 1'b0, '0);
    put(OP_ARRAYS, 3'd7, '0, 1'b0, '0);
    put(OP_RSVD, '1, '1, 1'b1, '1);               // unused op code
    put(OP_TICK, PRIM_POINTS, '0, 1'b0, 24'd1000);
    put(OP_TICK, PRIM_POINTS, '0, 1'b0, 24'd2000);
    put(OP_TICK, PRIM_POINTS, '0, 1'b0, 24'd1000);
    put(OP_TICK, PRIM_POINTS, '0, 1'b0, 24'd999); // second light: down to level 1
    put(OP_ARRAYS, PRIM_POINTS, 24'd100, 1'b0, '0);
    put(OP_ARRAYS, PRIM_TRIS, '0, 1'b0, '0);
    put(OP_TICK, PRIM_POINTS, '0, 1'b0, 24'd1999);
    wait_results();

    // disable keeps the level; draws all pass
    set_all(0, 1000, 2000, 12, 2, 2);
    put(OP_ARRAYS, PRIM_POINTS, '0, 1'b0, '0);
    put(OP_TICK, PRIM_POINTS, '0, 1'b0, '0);
    wait_results();
    set_all(1, 1000, 2000, 12, 2, 2);
    put(OP_ARRAYS, PRIM_POINTS, '0, 1'b0, '0);
    wait_results();

    // random phases over typical and extreme settings
    set_all(1, 1000, 2000, 12, 2, 3);
    run_random(200, 30, TM_MIXED, 1'b1);
    wait_results();
    set_all(1, 0, 0, 16'hFFFF, 1, 1);
    run_random(150, 25, TM_MIXED, 1'b0);
    wait_results();
    set_all(1, TIME_MAX, TIME_MAX, 0, 1, 1);
    run_random(150, 25, TM_MIXED, 1'b0);
    wait_results();
    set_all(1, 5000, 3000, 20, 3, 2);              // low limit above high
    run_random(150, 30, TM_MIXED, 1'b0);
    wait_results();
    set_all(1, 100, 200, 16'hFFFF, 255, 255);      // slowest hysteresis
    run_random(330, 95, TM_HEAVY, 1'b0);
    wait_results();
    run_random(340, 95, TM_LIGHT, 1'b0);
    wait_results();
    set_all(0, 100, 200, 16'hFFFF, 255, 255);
    run_random(60, 40, TM_MIXED, 1'b0);
    wait_results();
    set_all(1, 1000, 2000, 12, 2, 3);
    run_random(120, 30, TM_MIXED, 1'b1);
    wait_results();
    set_all(1, 32'(RST_LOW_LIMIT), 32'(RST_HIGH_LIMIT), 32'(RST_SMALL_BATCH),
            32'(RST_UP_FRAMES), 32'(RST_DOWN_FRAMES));
    run_random(110, 30, TM_MIXED, 1'b0);
    wait_results();

    repeat (8) @(posedge clk);
    if (verdict_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected result words never arrived", $time, verdict_q.size());
    end
    $display("Covered %0d words (%0d ticks, %0d draws dropped), %0d results compared.",
             queued_cnt, tick_cnt, drop_cnt, checked_cnt);
    $display("Words answered at level 2: %0d; mismatches: %0d.", heavy_words, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_draw_call_throttle_filter_top: done, clean");
    end else begin
      $display("tb_draw_call_throttle_filter_top: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("%0t: watchdog expired", $time);
    $display("tb_draw_call_throttle_filter_top: done, errors");
    $finish;
  end

endmodule

/* sim.f */
src/dctf_pkg.sv
src/draw_call_throttle_filter_top.sv
src/dctf_checker.sv
bench/tb_draw_call_throttle_filter_top.sv
